>>> hdl/tdd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and microcode ROM for the threshold disk dilation block.
// Used by threshold_disk_dilation; no dependencies of its own.

package tdd_pkg;

  // Default grid and radius limits
  localparam int GRID_X_DEF     = 64;
  localparam int GRID_Y_DEF     = 64;
  localparam int MAX_RADIUS_DEF = 15;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_RADIUS    = 1'b1;
  localparam logic [15:0] THRESHOLD_RST = 16'd410;
  localparam logic [7:0]  RADIUS_RST    = 8'd64;

  // Action codes
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [15:0] probability;
  } in_item_t;

  typedef struct packed {
    logic safe_bit;
    logic was_hot;
  } out_item_t;

  // Microcode step addresses
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] UC_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] UC_CLR    = 3'd1;
  localparam logic [STEP_W-1:0] UC_EMIT   = 3'd2;
  localparam logic [STEP_W-1:0] UC_DISK0  = 3'd3;
  localparam logic [STEP_W-1:0] UC_DISK   = 3'd4;
  localparam logic [STEP_W-1:0] UC_DISKE  = 3'd5;
  localparam logic [STEP_W-1:0] UC_RD     = 3'd6;
  localparam logic [STEP_W-1:0] UC_RD_CAP = 3'd7;

  typedef enum logic [2:0] {
    JMP_NEXT,      // fall through
    JMP_GOTO,      // always go to target
    JMP_DISPATCH,  // decode accepted transaction, stay while none
    JMP_UNTIL,     // go to target until the counter is at its last value
    JMP_IF_LAST,   // go to target when the counter is at its last value
    JMP_WAIT       // hold while the output register is full and stalled, then target
  } jmp_t;

  typedef struct packed {
    logic              accept;
    logic              clr_wr;
    logic              rd_row;
    logic              wr_row;
    logic              rd_cell;
    logic              cap_bit;
    logic              emit;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } uc_word_t;

  function automatic uc_word_t ucode(input logic [STEP_W-1:0] step);
    uc_word_t w;
    w = '{accept: 1'b0, clr_wr: 1'b0, rd_row: 1'b0, wr_row: 1'b0, rd_cell: 1'b0,
          cap_bit: 1'b0, emit: 1'b0, jmp: JMP_GOTO, target: UC_IDLE};
    case (step)
      UC_IDLE: begin
        w.accept = 1'b1;
        w.jmp    = JMP_DISPATCH;
      end
      UC_CLR: begin
        w.clr_wr = 1'b1;
        w.jmp    = JMP_UNTIL;
        w.target = UC_CLR;
      end
      UC_EMIT: begin
        w.emit   = 1'b1;
        w.jmp    = JMP_WAIT;
        w.target = UC_IDLE;
      end
      UC_DISK0: begin
        w.rd_row = 1'b1;
        w.jmp    = JMP_IF_LAST;
        w.target = UC_DISKE;
      end
      UC_DISK: begin
        w.rd_row = 1'b1;
        w.wr_row = 1'b1;
        w.jmp    = JMP_UNTIL;
        w.target = UC_DISK;
      end
      UC_DISKE: begin
        w.wr_row = 1'b1;
        w.jmp    = JMP_GOTO;
        w.target = UC_EMIT;
      end
      UC_RD: begin
        w.rd_cell = 1'b1;
        w.jmp     = JMP_NEXT;
      end
      UC_RD_CAP: begin
        w.cap_bit = 1'b1;
        w.jmp     = JMP_GOTO;
        w.target  = UC_EMIT;
      end
      default: begin
        w.jmp    = JMP_GOTO;
        w.target = UC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hdl/tdd_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module tdd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/threshold_disk_dilation.sv
`timescale 1ns / 1ps
// Top level: safety bitmap with disk dilation, microcoded row sequencer.
// Depends on tdd_pkg and tdd_ram.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  input    | in_valid / in_stall  | in_item  (action, cell_x, cell_y, prob)
//  output   | out_valid / out_stall| out_item (safe_bit, was_hot)
//  config   | APB psel/penable     | hot_threshold @0x0, disk_radius @0x4
//
// A hot write covers 2*S+1 rows, S the capped span floor(disk_radius/16). The
// bitmap is stored one row per RAM word and the disk touches one row word per
// cycle through the RAM's single write port.
// Reset starts a clearing pass over all rows and one empty emit step; no
// transaction is taken until both end, while configuration writes are taken.
// A stalled output holds the sequencer in its emit step.

module threshold_disk_dilation #(
  parameter int GRID_X     = tdd_pkg::GRID_X_DEF,
  parameter int GRID_Y     = tdd_pkg::GRID_Y_DEF,
  parameter int MAX_RADIUS = tdd_pkg::MAX_RADIUS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  tdd_pkg::in_item_t        in_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output tdd_pkg::out_item_t       out_item,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [tdd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  import tdd_pkg::*;

  localparam int COL_W  = $clog2(GRID_X);
  localparam int ROW_W  = $clog2(GRID_Y);
  localparam int SPAN_W = $clog2(MAX_RADIUS + 1);
  localparam int OFF_W  = SPAN_W + 1;
  localparam int D_W    = 2 * SPAN_W + 1;
  localparam int CMP_W  = (D_W + 8 > 16) ? D_W + 8 : 16;
  localparam int SUM_W  = ROW_W + 8;
  localparam int CS_W   = COL_W + 8;

  // Configuration registers
  logic [15:0] hot_threshold;
  logic [7:0]  disk_radius;
  logic [15:0] r2;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      hot_threshold <= THRESHOLD_RST;
      disk_radius   <= RADIUS_RST;
      r2            <= 16'(RADIUS_RST) * 16'(RADIUS_RST);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_THRESHOLD: hot_threshold <= pwdata[15:0];
        REG_RADIUS: begin
          disk_radius <= pwdata[7:0];
          r2          <= 16'(pwdata[7:0]) * 16'(pwdata[7:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD: prdata = {16'b0, hot_threshold};
      REG_RADIUS:    prdata = {24'b0, disk_radius};
      default:       prdata = '0;
    endcase
  end

  // Offset span, capped at MAX_RADIUS
  logic [SPAN_W-1:0] span;
  always_comb begin
    if ({4'b0, disk_radius[7:4]} > 8'(MAX_RADIUS)) begin
      span = SPAN_W'(MAX_RADIUS);
    end else begin
      span = SPAN_W'(disk_radius[7:4]);
    end
  end

  // Sequencer
  logic [STEP_W-1:0] step, step_next, dispatch;
  uc_word_t          cw;
  logic              last, clr_last, off_last, out_busy, accepted, emit_q, emit_fire;
  logic              in_grid, is_hot;

  assign cw        = ucode(step);
  assign in_stall  = !cw.accept;
  assign accepted  = in_valid && cw.accept;
  assign out_busy  = out_valid && out_stall;
  assign emit_fire = cw.emit && !out_busy && emit_q;

  assign in_grid = (32'(in_item.cell_x) < GRID_X) && (32'(in_item.cell_y) < GRID_Y);
  assign is_hot  = (in_item.action == ACT_WRITE) && in_grid &&
                   (in_item.probability >= hot_threshold);

  always_comb begin
    if (in_item.action == ACT_CLEAR) begin
      dispatch = UC_CLR;
    end else if (is_hot) begin
      dispatch = UC_DISK0;
    end else if ((in_item.action == ACT_READ) && in_grid) begin
      dispatch = UC_RD;
    end else begin
      dispatch = UC_EMIT;
    end
  end

  // Datapath state
  logic [ROW_W-1:0]        row_cnt;
  logic signed [OFF_W-1:0] off;
  logic [5:0]              cx_q, cy_q;
  logic                    res_safe, res_hot;

  assign clr_last = (row_cnt == ROW_W'(GRID_Y - 1));
  assign off_last = (off == $signed({1'b0, span}));
  assign last     = cw.clr_wr ? clr_last : off_last;

  always_comb begin
    case (cw.jmp)
      JMP_NEXT:     step_next = step + 1'b1;
      JMP_GOTO:     step_next = cw.target;
      JMP_DISPATCH: step_next = in_valid ? dispatch : step;
      JMP_UNTIL:    step_next = last ? step + 1'b1 : cw.target;
      JMP_IF_LAST:  step_next = last ? cw.target : step + 1'b1;
      JMP_WAIT:     step_next = out_busy ? step : cw.target;
      default:      step_next = UC_IDLE;
    endcase
  end

  // Row geometry for the offset being read
  logic signed [SUM_W-1:0] ty;
  logic                    ty_in;
  logic [SPAN_W-1:0]       mag;
  logic [2*SPAN_W-1:0]     dy2;
  logic [D_W-1:0]          d2;
  logic [SPAN_W-1:0]       row_w;
  logic                    row_hit;

  assign ty    = $signed(SUM_W'(cy_q)) + SUM_W'(off);
  assign ty_in = !ty[SUM_W-1] && (ty < $signed(SUM_W'(GRID_Y)));
  assign mag   = off[OFF_W-1] ? SPAN_W'(-off) : SPAN_W'(off);
  assign dy2   = (2*SPAN_W)'(mag) * (2*SPAN_W)'(mag);

  // Half-width of the disk on this row: largest dx inside both span and radius
  always_comb begin
    row_w   = '0;
    row_hit = 1'b0;
    d2      = '0;
    for (int i = 0; i <= MAX_RADIUS; i++) begin
      d2 = D_W'(i * i) + D_W'(dy2);
      if ((SPAN_W'(i) <= span) && (CMP_W'({d2, 8'b0}) <= CMP_W'(r2))) begin
        row_w = SPAN_W'(i);
        if (i == 0) begin
          row_hit = 1'b1;
        end
      end
    end
  end

  // Row pipeline between read and write of the disk rows
  logic [ROW_W-1:0]  pipe_row;
  logic              pipe_hit;
  logic [SPAN_W-1:0] pipe_w;

  always_ff @(posedge clk) begin
    if (cw.rd_row) begin
      pipe_row <= ty[ROW_W-1:0];
      pipe_hit <= ty_in && row_hit;
      pipe_w   <= row_w;
    end
  end

  logic signed [CS_W-1:0] lo, hi;
  logic [GRID_X-1:0]      mask;

  assign lo = $signed(CS_W'(cx_q)) - $signed(CS_W'(pipe_w));
  assign hi = $signed(CS_W'(cx_q)) + $signed(CS_W'(pipe_w));

  always_comb begin
    for (int c = 0; c < GRID_X; c++) begin
      mask[c] = ($signed(CS_W'(c)) >= lo) && ($signed(CS_W'(c)) <= hi);
    end
  end

  // Bitmap storage, one row per word
  logic              ram_we, ram_re;
  logic [ROW_W-1:0]  ram_waddr, ram_raddr;
  logic [GRID_X-1:0] ram_wdata, ram_rdata;
  logic [COL_W-1:0]  rd_col;

  assign ram_we    = cw.clr_wr || (cw.wr_row && pipe_hit);
  assign ram_waddr = cw.clr_wr ? row_cnt : pipe_row;
  assign ram_wdata = cw.clr_wr ? '1 : (ram_rdata & ~mask);
  assign ram_re    = (cw.rd_row && ty_in) || cw.rd_cell;
  assign ram_raddr = cw.rd_row ? ty[ROW_W-1:0] : ROW_W'(cy_q);
  assign rd_col    = COL_W'(cx_q);

  tdd_ram #(
    .WIDTH(GRID_X),
    .DEPTH(GRID_Y)
  ) u_bitmap (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= UC_CLR;
      row_cnt <= '0;
      emit_q  <= 1'b0;
    end else begin
      step <= step_next;
      if (accepted) begin
        emit_q  <= 1'b1;
        row_cnt <= '0;
      end else if (cw.clr_wr) begin
        row_cnt <= row_cnt + 1'b1;
      end
      if (emit_fire) begin
        emit_q <= 1'b0;
      end
    end
  end

  // Transaction payload, no reset needed
  always_ff @(posedge clk) begin
    if (accepted) begin
      cx_q     <= in_item.cell_x;
      cy_q     <= in_item.cell_y;
      off      <= -$signed({1'b0, span});
      res_hot  <= is_hot;
      res_safe <= 1'b0;
    end else begin
      if (cw.rd_row) begin
        off <= off + 1'b1;
      end
      if (cw.cap_bit) begin
        res_safe <= ram_rdata[rd_col];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_item.safe_bit <= res_safe;
      out_item.was_hot  <= res_hot;
    end
  end

  // Checks
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (step == UC_IDLE) |-> !ram_we)
    else $error("bitmap written while idle");

  a_row_rw_apart: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("same row read and written in one cycle");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    cw.wr_row |-> $past(cw.rd_row))
    else $error("disk row written without a preceding read");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step == UC_EMIT))
    else $error("result raised outside the emit step");

endmodule

>>> test/threshold_disk_dilation_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for threshold_disk_dilation: predicts each result from its
// own safety map, drives random bursts, stalls and register settings.
// Depends on tdd_pkg and the threshold_disk_dilation RTL.

module threshold_disk_dilation_test;
  import tdd_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 80;   // longer than a full clear
  localparam int PHASE_ITEMS  = 237;
  localparam int PRINT_MAX    = 50;

  localparam logic [1:0]        ACT_UNUSED     = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_RADIUS    = {REG_RADIUS, 2'b00};

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow of the block's state
  logic               safety_map [GRID_Y_DEF][GRID_X_DEF];
  logic [15:0]        threshold_q;
  logic [7:0]         radius_q;
  out_item_t          pending_results [$];

  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int last_x = 0;
  int last_y = 0;

  threshold_disk_dilation i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < PRINT_MAX)
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic void reset_map();
    foreach (safety_map[y, x]) safety_map[y][x] = 1'b1;
  endfunction

  function automatic void mark_disk_at(input int cx, input int cy);
    int span;
    int r2;
    int tx;
    int ty;
    span = int'(radius_q) >> 4;
    if (span > MAX_RADIUS_DEF) span = MAX_RADIUS_DEF;
    r2 = int'(radius_q) * int'(radius_q);
    for (int dx = -span; dx <= span; dx++) begin
      tx = cx + dx;
      if (tx >= 0 && tx < GRID_X_DEF) begin
        for (int dy = -span; dy <= span; dy++) begin
          ty = cy + dy;
          if (ty >= 0 && ty < GRID_Y_DEF && (dx * dx + dy * dy) * 256 <= r2)
            safety_map[ty][tx] = 1'b0;
        end
      end
    end
  endfunction

  function automatic out_item_t apply_map_action(input in_item_t it);
    out_item_t r;
    r = '0;
    case (it.action)
      ACT_CLEAR: begin
        reset_map();
      end
      ACT_WRITE: begin
        if (it.probability >= threshold_q) begin
          mark_disk_at(int'(it.cell_x), int'(it.cell_y));
          r.was_hot = 1'b1;
        end
      end
      ACT_READ: begin
        r.safe_bit = safety_map[it.cell_y][it.cell_x];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t make_item(input logic [1:0] act, input int x, input int y,
                                         input int p);
    in_item_t it;
    it.action      = act;
    it.cell_x      = x[5:0];
    it.cell_y      = y[5:0];
    it.probability = p[15:0];
    return it;
  endfunction

  function automatic int clamp(input int v, input int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  // Favor the border rows and columns so disks get clipped often
  function automatic int pick_coord();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(62, 63);
    return $urandom_range(0, 63);
  endfunction

  function automatic int pick_probability();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 65535);
    return clamp(int'(threshold_q) + $urandom_range(0, 6) - 3, 65535);
  endfunction

  // Send one transaction; bursts of random length separated by random gaps
  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_map_action(it));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
    logic [31:0] want;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_THRESHOLD) begin
      threshold_q = value[15:0];
      want = {16'b0, value[15:0]};
    end else begin
      radius_q = value[7:0];
      want = {24'b0, value[7:0]};
    end
    // read it back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_THRESHOLD) begin
      if (prdata[15:0] != want[15:0])
        report_mismatch("hot_threshold readback", prdata[15:0], want[15:0]);
    end else if (prdata[7:0] != want[7:0]) begin
      report_mismatch("disk_radius readback", prdata[7:0], want[7:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input int thr, input int rad);
    wait_idle();
    write_config(ADDR_THRESHOLD, thr & 32'hFFFF);
    write_config(ADDR_RADIUS, rad & 32'hFF);
  endtask

  // Receiver: stall pattern chosen by bits 9:8 of the cycle count; check accepted results
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_item.safe_bit !== want.safe_bit)
          report_mismatch("safe_bit", out_item.safe_bit, want.safe_bit);
        if (out_item.was_hot !== want.was_hot)
          report_mismatch("was_hot", out_item.was_hot, want.was_hot);
      end
    end
    case (cycles[9:8])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= cycles[4];
    endcase
  end

  task automatic test_reset_state();
    send_item(make_item(ACT_READ, 0, 0, 0));
    send_item(make_item(ACT_READ, 63, 63, 65535));
    send_item(make_item(ACT_READ, 17, 42, 0));
  endtask

  // Default radius 4.0: disk clipped at corners, threshold boundary, unused action
  task automatic test_disk_edges();
    send_item(make_item(ACT_UNUSED, 63, 63, 65535));
    send_item(make_item(ACT_WRITE, 0, 0, 65535));
    send_item(make_item(ACT_READ, 4, 0, 0));
    send_item(make_item(ACT_READ, 5, 0, 0));
    send_item(make_item(ACT_READ, 3, 3, 0));
    send_item(make_item(ACT_READ, 2, 3, 0));
    send_item(make_item(ACT_WRITE, 63, 63, THRESHOLD_RST));
    send_item(make_item(ACT_READ, 63, 59, 0));
    send_item(make_item(ACT_WRITE, 32, 32, THRESHOLD_RST - 1));
    send_item(make_item(ACT_READ, 32, 32, 0));
    send_item(make_item(ACT_WRITE, 63, 0, 0));
    send_item(make_item(ACT_CLEAR, 63, 63, 65535));
    send_item(make_item(ACT_READ, 0, 0, 0));
  endtask

  task automatic test_radius_extremes();
    set_config(THRESHOLD_RST, 0);
    send_item(make_item(ACT_WRITE, 10, 10, 65535));
    send_item(make_item(ACT_READ, 10, 10, 0));
    send_item(make_item(ACT_READ, 11, 10, 0));
    send_item(make_item(ACT_READ, 10, 9, 0));
    set_config(0, 255);
    send_item(make_item(ACT_CLEAR, 0, 0, 0));
    send_item(make_item(ACT_WRITE, 31, 31, 0));
    send_item(make_item(ACT_READ, 16, 31, 0));
    send_item(make_item(ACT_READ, 16, 16, 0));
    send_item(make_item(ACT_READ, 31, 47, 0));
  endtask

  // Writes at random cells mixed with reads, mostly around the last disk
  task automatic run_map_phase(input int count);
    int pick;
    int span;
    send_item(make_item(ACT_CLEAR, $urandom, $urandom, $urandom));
    span = (int'(radius_q) >> 4) + 2;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        last_x = pick_coord();
        last_y = pick_coord();
        send_item(make_item(ACT_WRITE, last_x, last_y, pick_probability()));
      end else if (pick < 80) begin
        send_item(make_item(ACT_READ,
                            clamp(last_x + $urandom_range(0, 2 * span) - span, 63),
                            clamp(last_y + $urandom_range(0, 2 * span) - span, 63),
                            $urandom));
      end else if (pick < 88) begin
        send_item(make_item(ACT_READ, $urandom, $urandom, $urandom));
      end else if (pick < 95) begin
        send_item(make_item(ACT_WRITE, $urandom, $urandom, $urandom));
      end else if (pick < 98) begin
        send_item(make_item(ACT_UNUSED, $urandom, $urandom, $urandom));
      end else begin
        send_item(make_item(ACT_CLEAR, $urandom, $urandom, $urandom));
      end
    end
  endtask

  task automatic test_random_settings();
    set_config(THRESHOLD_RST, RADIUS_RST);
    run_map_phase(PHASE_ITEMS);
    set_config(0, 0);
    run_map_phase(PHASE_ITEMS);
    set_config(16'hFFFF, 255);
    run_map_phase(PHASE_ITEMS);
    set_config(16'h1000, 16);
    run_map_phase(PHASE_ITEMS);
    set_config($urandom_range(0, 65535), $urandom_range(0, 255));
    run_map_phase(PHASE_ITEMS);
    set_config($urandom_range(0, 65535), $urandom_range(0, 255));
    run_map_phase(PHASE_ITEMS);
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_item   <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    threshold_q = THRESHOLD_RST;
    radius_q    = RADIUS_RST;
    reset_map();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_disk_edges();
    test_radius_extremes();
    test_random_settings();
    wait_idle();

    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
hdl/tdd_pkg.sv
hdl/tdd_ram.sv
hdl/threshold_disk_dilation.sv
test/threshold_disk_dilation_test.sv
